/* sv/trap_int_pkg.sv */
// Shared constants, codes and types of the trapezoid running integral block.
package trap_int_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SIGMA_BITS      = 12;
    localparam int S2_BITS         = 2 * SIGMA_BITS + 1;
    localparam int INTEG_BITS      = 48;
    localparam int ERROR_BITS      = 32;
    localparam int VAR_BITS        = 64;
    localparam int MODE_BITS       = 2;

    localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd0;
    localparam int MODE_X_BIT = 0;
    localparam int MODE_Y_BIT = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT,
        ST_SUM,
        ST_VAR,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_IXY,
        OP_ADY2,
        OP_ADX2,
        OP_PSX2,
        OP_SX2,
        OP_PSY2,
        OP_SY2,
        OP_XLO,
        OP_XHI,
        OP_YLO,
        OP_YHI
    } mul_op_t;

endpackage

/* sv/trap_int_mul.sv */
// Shared unsigned multiplier with registered product.
module trap_int_mul #(
    parameter int W = 25
) (
    input  logic           clk,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);
    logic [2*W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

/* sv/trap_int_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
module trap_int_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [trap_int_pkg::VAR_BITS-1:0] value,
    output logic                              done,
    output logic [trap_int_pkg::ERROR_BITS-1:0] root
);
    import trap_int_pkg::*;

    localparam int STEPS = VAR_BITS / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VAR_BITS-1:0] rem_reg, rem_next;
    logic [VAR_BITS-1:0] res_reg, res_next;
    logic [VAR_BITS-1:0] bit_reg, bit_next;
    logic [VAR_BITS-1:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = value;
            res_next  = '0;
            bit_next  = VAR_BITS'(1) << (VAR_BITS - 2);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ERROR_BITS-1:0];
endmodule

/* sv/trapezoid_running_integral.sv */
// Top level: trapezoid running integral with error propagation.
//
// Input stream s_*: one sample per request. s_tuser is the first-sample flag
// that starts a new series; s_tdata packs sample_x, sample_y, sigma_x and
// sigma_y from bit 0 up. Output stream m_*: one result per request, with
// integral_x2 and error_x2 in m_tdata and the saturation flag in m_tuser.
// Both values carry one fractional bit (twice the true integral and error).
// cfg_we/cfg_wdata write error_mode; write it only while the block is idle.
//
// A continuing sample, once accepted, makes 11 passes through the one shared
// multiplier, drains it in ST_WAIT, accumulates in ST_SUM and ST_VAR, runs 32
// bit-serial square-root steps, waits for the root's registered done flag and
// loads the output register in ST_DONE; a new sample is taken only back in
// idle, after the result is loaded. A first sample goes straight to ST_DONE,
// skipping the multiplier and the root. s_tready is high only while idle.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver stalls, the following result holds in the final
// state until the register frees.
// Reset clears the previous sample, both accumulators, the flag and
// error_mode; the first result after reset continues from an all-zero sample.
module trapezoid_running_integral #(
    parameter int SAMPLE_BITS = trap_int_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // s_tdata: sample_x, sample_y, sigma_x, sigma_y (from bit 0), zero pad
    input  logic [((2*SAMPLE_BITS+2*trap_int_pkg::SIGMA_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: first_sample
    input  logic s_tuser,
    input  logic s_tvalid,
    output logic s_tready,
    // m_tdata: integral_x2 [47:0], error_x2 [79:48]
    output logic [trap_int_pkg::INTEG_BITS+trap_int_pkg::ERROR_BITS-1:0] m_tdata,
    // m_tuser: saturated
    output logic m_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic cfg_we,
    input  logic [trap_int_pkg::MODE_BITS-1:0] cfg_wdata
);
    import trap_int_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 1;
    localparam int MW = (DW > S2_BITS) ? DW : S2_BITS;
    localparam int PW = 2 * MW;
    localparam int WW = 3 * MW + 1;
    localparam int IW = PW + 2;
    localparam int OW = INTEG_BITS + ERROR_BITS;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    mul_op_t cons_op_reg, cons_op_next;
    logic    cons_vld_reg, cons_vld_next;
    logic    m_tvalid_reg, m_tvalid_next;

    logic [MODE_BITS-1:0]  error_mode_reg, error_mode_next;
    logic [SB-1:0]         prev_x_reg, prev_x_next;
    logic [SB-1:0]         prev_y_reg, prev_y_next;
    logic [SIGMA_BITS-1:0] psx_reg, psx_next, sx_reg, sx_next;
    logic [SIGMA_BITS-1:0] psy_reg, psy_next, sy_reg, sy_next;
    logic [INTEG_BITS-1:0] integral_reg, integral_next;
    logic [VAR_BITS-1:0]   variance_reg, variance_next;
    logic                  sat_reg, sat_next;

    logic [DW-1:0]         ady_reg, ady_next, adx_reg, adx_next;
    logic                  neg_reg, neg_next;
    logic                  first_reg, first_next;
    logic [PW-1:0]         pmag_reg, pmag_next;
    logic [PW-1:0]         a2_reg, a2_next, b2_reg, b2_next;
    logic [S2_BITS-1:0]    s2x_reg, s2x_next, s2y_reg, s2y_next;
    logic [PW-1:0]         tlo_reg, tlo_next;
    logic [VAR_BITS-1:0]   termx_reg, termx_next, termy_reg, termy_next;
    logic [VAR_BITS-1:0]   term_reg, term_next;
    logic [OW-1:0]         out_data_reg, out_data_next;
    logic                  out_sat_reg, out_sat_next;

    logic [SB-1:0]         samp_x, samp_y;
    logic [SIGMA_BITS-1:0] sig_x, sig_y;
    logic [DW-1:0]         dy, dx;
    logic [MW-1:0]         mul_a, mul_b;
    logic [PW-1:0]         mul_p;
    logic [WW-1:0]         wide;
    logic [IW-1:0]         acc_ext, mag_ext, sprod, isum;
    logic [VAR_BITS:0]     tsum, vsum;
    logic [VAR_BITS-1:0]   tx, ty;
    logic                  sq_start, sq_done;
    logic [ERROR_BITS-1:0] sq_root;

    assign samp_x = s_tdata[SB-1:0];
    assign samp_y = s_tdata[2*SB-1:SB];
    assign sig_x  = s_tdata[2*SB+SIGMA_BITS-1:2*SB];
    assign sig_y  = s_tdata[2*SB+2*SIGMA_BITS-1:2*SB+SIGMA_BITS];

    assign dy = {samp_y[SB-1], samp_y} + {prev_y_reg[SB-1], prev_y_reg};
    assign dx = {samp_x[SB-1], samp_x} - {prev_x_reg[SB-1], prev_x_reg};

    trap_int_mul #(.W(MW)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    trap_int_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (variance_next),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cons_op_next    = cons_op_reg;
        cons_vld_next   = 1'b0;
        m_tvalid_next   = m_tvalid_reg;
        error_mode_next = error_mode_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        psx_next        = psx_reg;
        sx_next         = sx_reg;
        psy_next        = psy_reg;
        sy_next         = sy_reg;
        integral_next   = integral_reg;
        variance_next   = variance_reg;
        sat_next        = sat_reg;
        ady_next        = ady_reg;
        adx_next        = adx_reg;
        neg_next        = neg_reg;
        first_next      = first_reg;
        pmag_next       = pmag_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        s2x_next        = s2x_reg;
        s2y_next        = s2y_reg;
        tlo_next        = tlo_reg;
        termx_next      = termx_reg;
        termy_next      = termy_reg;
        term_next       = term_reg;
        out_data_next   = out_data_reg;
        out_sat_next    = out_sat_reg;
        mul_a           = '0;
        mul_b           = '0;
        sq_start        = 1'b0;
        s_tready        = (state_reg == ST_IDLE);

        wide    = WW'({mul_p, {MW{1'b0}}}) + WW'(tlo_reg);
        acc_ext = {{(IW-INTEG_BITS){integral_reg[INTEG_BITS-1]}}, integral_reg};
        mag_ext = IW'(pmag_reg);
        sprod   = neg_reg ? (IW'(0) - mag_ext) : mag_ext;
        isum    = acc_ext + sprod;
        tx      = error_mode_reg[MODE_X_BIT] ? termx_reg : '0;
        ty      = error_mode_reg[MODE_Y_BIT] ? termy_reg : '0;
        tsum    = (VAR_BITS+1)'(tx) + (VAR_BITS+1)'(ty);
        vsum    = (VAR_BITS+1)'(variance_reg) + (VAR_BITS+1)'(term_reg);

        if (cfg_we)
            error_mode_next = cfg_wdata;
        if (m_tready)
            m_tvalid_next = 1'b0;

        // product of the previous multiplier pass
        if (cons_vld_reg)
        begin
            case (cons_op_reg)
                OP_IXY:  pmag_next = mul_p;
                OP_ADY2: a2_next = mul_p;
                OP_ADX2: b2_next = mul_p;
                OP_PSX2: s2x_next = S2_BITS'(mul_p);
                OP_SX2:  s2x_next = s2x_reg + S2_BITS'(mul_p);
                OP_PSY2: s2y_next = S2_BITS'(mul_p);
                OP_SY2:  s2y_next = s2y_reg + S2_BITS'(mul_p);
                OP_XLO, OP_YLO: tlo_next = mul_p;
                OP_XHI:
                begin
                    if (|wide[WW-1:VAR_BITS])
                    begin
                        termx_next = '1;
                        if (error_mode_reg[MODE_X_BIT])
                            sat_next = 1'b1;
                    end
                    else
                        termx_next = wide[VAR_BITS-1:0];
                end
                OP_YHI:
                begin
                    if (|wide[WW-1:VAR_BITS])
                    begin
                        termy_next = '1;
                        if (error_mode_reg[MODE_Y_BIT])
                            sat_next = 1'b1;
                    end
                    else
                        termy_next = wide[VAR_BITS-1:0];
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    prev_x_next = samp_x;
                    prev_y_next = samp_y;
                    psx_next    = sx_reg;
                    sx_next     = sig_x;
                    psy_next    = sy_reg;
                    sy_next     = sig_y;
                    neg_next    = dy[DW-1] ^ dx[DW-1];
                    ady_next    = dy[DW-1] ? (DW'(0) - dy) : dy;
                    adx_next    = dx[DW-1] ? (DW'(0) - dx) : dx;
                    first_next  = s_tuser;
                    if (s_tuser)
                    begin
                        integral_next = '0;
                        variance_next = '0;
                        sat_next      = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        op_next    = OP_IXY;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                case (op_reg)
                    OP_IXY:  begin mul_a = MW'(ady_reg); mul_b = MW'(adx_reg); end
                    OP_ADY2: begin mul_a = MW'(ady_reg); mul_b = MW'(ady_reg); end
                    OP_ADX2: begin mul_a = MW'(adx_reg); mul_b = MW'(adx_reg); end
                    OP_PSX2: begin mul_a = MW'(psx_reg); mul_b = MW'(psx_reg); end
                    OP_SX2:  begin mul_a = MW'(sx_reg);  mul_b = MW'(sx_reg);  end
                    OP_PSY2: begin mul_a = MW'(psy_reg); mul_b = MW'(psy_reg); end
                    OP_SY2:  begin mul_a = MW'(sy_reg);  mul_b = MW'(sy_reg);  end
                    OP_XLO:  begin mul_a = a2_reg[MW-1:0];  mul_b = MW'(s2x_reg); end
                    OP_XHI:  begin mul_a = a2_reg[PW-1:MW]; mul_b = MW'(s2x_reg); end
                    OP_YLO:  begin mul_a = b2_reg[MW-1:0];  mul_b = MW'(s2y_reg); end
                    OP_YHI:  begin mul_a = b2_reg[PW-1:MW]; mul_b = MW'(s2y_reg); end
                    default: ;
                endcase
                cons_vld_next = 1'b1;
                cons_op_next  = op_reg;
                if (op_reg == OP_YHI)
                    state_next = ST_WAIT;
                else
                    op_next = mul_op_t'(op_reg + 4'd1);
            end
            ST_WAIT:
                state_next = ST_SUM;
            ST_SUM:
            begin
                if ((&isum[IW-1:INTEG_BITS-1]) || !(|isum[IW-1:INTEG_BITS-1]))
                    integral_next = isum[INTEG_BITS-1:0];
                else
                begin
                    sat_next      = 1'b1;
                    integral_next = isum[IW-1] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                               : {1'b0, {(INTEG_BITS-1){1'b1}}};
                end
                if (tsum[VAR_BITS])
                begin
                    term_next = '1;
                    sat_next  = 1'b1;
                end
                else
                    term_next = tsum[VAR_BITS-1:0];
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                if (error_mode_reg == MODE_NONE)
                    variance_next = '0;
                else if (vsum[VAR_BITS])
                begin
                    variance_next = '1;
                    sat_next      = 1'b1;
                end
                else
                    variance_next = vsum[VAR_BITS-1:0];
                sq_start   = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sq_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {first_reg ? '0 : sq_root, integral_reg};
                    out_sat_next  = sat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_IXY;
            cons_op_reg    <= OP_IXY;
            cons_vld_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            error_mode_reg <= MODE_NONE;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            psx_reg        <= '0;
            sx_reg         <= '0;
            psy_reg        <= '0;
            sy_reg         <= '0;
            integral_reg   <= '0;
            variance_reg   <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cons_op_reg    <= cons_op_next;
            cons_vld_reg   <= cons_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
            error_mode_reg <= error_mode_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            psx_reg        <= psx_next;
            sx_reg         <= sx_next;
            psy_reg        <= psy_next;
            sy_reg         <= sy_next;
            integral_reg   <= integral_next;
            variance_reg   <= variance_next;
            sat_reg        <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ady_reg      <= ady_next;
        adx_reg      <= adx_next;
        neg_reg      <= neg_next;
        first_reg    <= first_next;
        pmag_reg     <= pmag_next;
        a2_reg       <= a2_next;
        b2_reg       <= b2_next;
        s2x_reg      <= s2x_next;
        s2y_reg      <= s2y_next;
        tlo_reg      <= tlo_next;
        termx_reg    <= termx_next;
        termy_reg    <= termy_next;
        term_reg     <= term_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == ST_SQRT)
        else $error("square root finished outside its wait state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg != ST_IDLE)
        else $error("accepted request did not start work");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the final state");

    a_mul_drains: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> !cons_vld_reg)
        else $error("multiplier product still pending at accumulate");
`endif
endmodule
